### sv/pph_pkg.sv
// Package for the perturbed probe hash table: sizes, request and status codes, word types.
`timescale 1ns / 1ps

package pph_pkg;

   localparam int SLOT_BITS          = 10;
   localparam int SLOT_DEPTH         = 1 << SLOT_BITS;
   localparam int HASH_WIDTH         = 64;
   localparam int KEY_WIDTH          = 64;
   localparam int VALUE_WIDTH        = 32;
   localparam int PROBE_SHIFT        = 5;
   localparam int ZERO_PERTURB_STEPS = 13;
   localparam int MIN_LOG2           = 2;
   localparam int SIZE_RESET         = 10;
   localparam int SIZE_W             = 4;
   localparam int LOG2_W             = $clog2(SLOT_BITS + 1);
   localparam int PROBE_W            = $clog2(SLOT_DEPTH + ZERO_PERTURB_STEPS + 1);
   localparam int OCC_W              = SLOT_BITS + 1;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FOUND   = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [HASH_WIDTH-1:0]  hash_bits;
      logic [KEY_WIDTH-1:0]   search_key;
      logic [VALUE_WIDTH-1:0] entry_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [VALUE_WIDTH-1:0] found_value;
      logic [SLOT_BITS-1:0]   slot_index;
   } rsp_word_type;

   typedef struct packed {
      logic                   occupied;
      logic [HASH_WIDTH-1:0]  hash_bits;
      logic [KEY_WIDTH-1:0]   search_key;
      logic [VALUE_WIDTH-1:0] entry_value;
   } slot_word_type;

endpackage

### sv/perturbed_probe_hash_table_core.sv
// Open-addressing hash table engine with perturbation probing over one slot memory.
//
//   Port group   Direction   Carries
//   req_         in          one request word: type, hash, key, value
//   rsp_         out         one result word: status, value, slot
//   csr_         in          write of table_size_log2
//
// An insert or lookup walks the slot memory, issuing one read of it per cycle; the data of each
// read is registered and checked in the following cycle, and the walk stops at its result.
// A clear request sweeps all slots, one per cycle, before its result.
// After reset the same sweep runs, during which req_stall stays high.
// A request is taken while an earlier result still waits under rsp_stall; its own result then
// waits in a holding register until the output word is taken.
`timescale 1ns / 1ps

module perturbed_probe_hash_table_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pph_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pph_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic [pph_pkg::SIZE_W-1:0] csr_wr_data
);
   import pph_pkg::*;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PROBE,
      ST_RESPOND
   } state_type;

   state_type              state_ff, state_in;
   logic [SLOT_BITS-1:0]   sweep_ff, sweep_in;
   logic                   clr_reply_ff, clr_reply_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   req_word_type           req_ff, req_in;
   logic [SLOT_BITS-1:0]   mask_ff, mask_in;
   logic [PROBE_W-1:0]     limit_ff, limit_in;
   logic [SLOT_BITS-1:0]   addr_ff, addr_in;
   logic [HASH_WIDTH-1:0]  perturb_ff, perturb_in;
   logic [PROBE_W-1:0]     issued_ff, issued_in;
   logic                   rdv_ff, rdv_in;
   logic [SLOT_BITS-1:0]   rd_slot_ff, rd_slot_in;
   logic                   rd_last_ff, rd_last_in;
   rsp_word_type           hold_ff, hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_ff, rsp_in;

   slot_word_type          slot_mem [SLOT_DEPTH];
   slot_word_type          mem_q_ff;

   logic                   wr_en;
   logic [SLOT_BITS-1:0]   wr_addr;
   slot_word_type          wr_data;

   logic [LOG2_W-1:0]      size_log2;
   logic [SLOT_BITS-1:0]   mask;
   logic [PROBE_W-1:0]     count;
   logic                   req_accept;
   logic                   out_free;
   logic                   fin;
   rsp_word_type           fin_word;
   logic [HASH_WIDTH-1:0]  perturb_next;
   logic [SLOT_BITS-1:0]   addr_next;
   logic                   slot_empty;
   logic                   slot_match;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   always_comb begin
      if (size_ff < SIZE_W'(MIN_LOG2)) begin
         size_log2 = LOG2_W'(MIN_LOG2);
      end else if (size_ff > SIZE_W'(SLOT_BITS)) begin
         size_log2 = LOG2_W'(SLOT_BITS);
      end else begin
         size_log2 = LOG2_W'(size_ff);
      end
   end

   assign mask  = ~({SLOT_BITS{1'b1}} << size_log2);
   assign count = PROBE_W'(1) << size_log2;

   assign perturb_next = perturb_ff >> PROBE_SHIFT;
   assign addr_next    = ((addr_ff << 2) + addr_ff + SLOT_BITS'(1)
                         + perturb_next[SLOT_BITS-1:0]) & mask_ff;

   assign slot_empty = !mem_q_ff.occupied;
   assign slot_match = (req_ff.req_type == REQ_LOOKUP) && mem_q_ff.occupied
                       && (mem_q_ff.hash_bits == req_ff.hash_bits)
                       && (mem_q_ff.search_key == req_ff.search_key);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      clr_reply_in = clr_reply_ff;
      occ_in       = occ_ff;
      size_in      = size_ff;
      req_in       = req_ff;
      mask_in      = mask_ff;
      limit_in     = limit_ff;
      addr_in      = addr_ff;
      perturb_in   = perturb_ff;
      issued_in    = issued_ff;
      rdv_in       = 1'b0;
      rd_slot_in   = rd_slot_ff;
      rd_last_in   = rd_last_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_slot_ff;
      wr_data      = '0;
      fin          = 1'b0;
      fin_word     = '0;

      if (csr_wr_en) begin
         size_in = csr_wr_data;
      end

      case (state_ff)
         ST_SWEEP: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            sweep_in = sweep_ff + SLOT_BITS'(1);
            if (sweep_ff == {SLOT_BITS{1'b1}}) begin
               if (clr_reply_ff) begin
                  fin             = 1'b1;
                  fin_word.status = STATUS_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               req_in     = req_word;
               mask_in    = mask;
               limit_in   = count + PROBE_W'(ZERO_PERTURB_STEPS);
               addr_in    = req_word.hash_bits[SLOT_BITS-1:0] & mask;
               perturb_in = req_word.hash_bits;
               issued_in  = '0;
               case (req_word.req_type)
                  REQ_CLEAR: begin
                     state_in     = ST_SWEEP;
                     sweep_in     = '0;
                     occ_in       = '0;
                     clr_reply_in = 1'b1;
                  end
                  REQ_INSERT: begin
                     if (PROBE_W'(occ_ff) + PROBE_W'(1) >= count) begin
                        fin             = 1'b1;
                        fin_word.status = STATUS_FULL;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  REQ_LOOKUP: begin
                     state_in = ST_PROBE;
                  end
                  default: begin
                     fin             = 1'b1;
                     fin_word.status = STATUS_MISSING;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (rdv_ff && slot_empty) begin
               fin = 1'b1;
               if (req_ff.req_type == REQ_INSERT) begin
                  wr_en                = 1'b1;
                  wr_data.occupied     = 1'b1;
                  wr_data.hash_bits    = req_ff.hash_bits;
                  wr_data.search_key   = req_ff.search_key;
                  wr_data.entry_value  = req_ff.entry_value;
                  occ_in               = occ_ff + OCC_W'(1);
                  fin_word.status      = STATUS_DONE;
                  fin_word.slot_index  = rd_slot_ff;
               end else begin
                  fin_word.status = STATUS_MISSING;
               end
            end else if (rdv_ff && slot_match) begin
               fin                  = 1'b1;
               fin_word.status      = STATUS_FOUND;
               fin_word.found_value = mem_q_ff.entry_value;
               fin_word.slot_index  = rd_slot_ff;
            end else if (rdv_ff && rd_last_ff) begin
               fin             = 1'b1;
               fin_word.status = (req_ff.req_type == REQ_INSERT) ? STATUS_FULL
                                                                 : STATUS_MISSING;
            end else if (issued_ff < limit_ff) begin
               rdv_in     = 1'b1;
               rd_slot_in = addr_ff;
               rd_last_in = (issued_ff == limit_ff - PROBE_W'(1));
               issued_in  = issued_ff + PROBE_W'(1);
               perturb_in = perturb_next;
               addr_in    = addr_next;
            end
         end
         ST_RESPOND: begin
            if (out_free) begin
               rsp_in       = hold_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         if (out_free) begin
            rsp_in       = fin_word;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            hold_in  = fin_word;
            state_in = ST_RESPOND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= slot_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      mask_ff    <= mask_in;
      limit_ff   <= limit_in;
      addr_ff    <= addr_in;
      perturb_ff <= perturb_in;
      issued_ff  <= issued_in;
      rd_slot_ff <= rd_slot_in;
      rd_last_ff <= rd_last_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         clr_reply_ff <= 1'b0;
         occ_ff       <= '0;
         size_ff      <= SIZE_W'(SIZE_RESET);
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_reply_ff <= clr_reply_in;
         occ_ff       <= occ_in;
         size_ff      <= size_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // At least one slot always stays empty, so the count never reaches the depth.
   assert property (@(posedge clock) disable iff (reset)
      occ_ff < OCC_W'(SLOT_DEPTH))
      else $error("occupied count reached the slot depth");

   // A sweep only ever runs on an emptied table.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (occ_ff == '0))
      else $error("occupied count not zero during a sweep");

   // Every slot written by a walk adds exactly one to the occupied count.
   assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_PROBE)) |=> (occ_ff == $past(occ_ff) + OCC_W'(1)))
      else $error("insert write without count update");

   // Returned read data belongs to a walk in progress.
   assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> (state_ff == ST_PROBE))
      else $error("slot read data outside a walk");

   // A held result only exists while the output word is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESPOND) |-> rsp_valid_ff)
      else $error("held result without a waiting output word");

endmodule

### tb/pph_checker.sv
// Checker for the hash table core: predicts each response from its own copy of the table.
`timescale 1ns / 1ps

module pph_checker
   import pph_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_word_type      req_word,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_word_type      rsp_word,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   output int                fail_count,
   output int                pending
);

   localparam int PROBE_MUL = 5;

   logic [SIZE_W-1:0]      size_log2 = SIZE_W'(SIZE_RESET);
   logic                   occupied [SLOT_DEPTH];
   logic [HASH_WIDTH-1:0]  stored_hash [SLOT_DEPTH];
   logic [KEY_WIDTH-1:0]   stored_key [SLOT_DEPTH];
   logic [VALUE_WIDTH-1:0] stored_value [SLOT_DEPTH];
   int unsigned            entry_count;
   rsp_word_type           awaited_rsp_q[$];
   rsp_word_type           want;

   // Applies one request to the table copy and returns the response it should give.
   function automatic rsp_word_type probe_table(input req_word_type w);
      rsp_word_type          r;
      int                    lg;
      int unsigned           slots;
      logic [63:0]           mask;
      logic [63:0]           perturb;
      logic [63:0]           slot;
      logic [SLOT_BITS-1:0]  s;
      r  = '0;
      lg = int'(size_log2);
      if (lg < MIN_LOG2) lg = MIN_LOG2;
      if (lg > SLOT_BITS) lg = SLOT_BITS;
      slots = 1 << lg;
      mask  = 64'(slots) - 64'd1;
      if (w.req_type == REQ_CLEAR) begin
         for (int i = 0; i < SLOT_DEPTH; i++) occupied[i] = 1'b0;
         entry_count = 0;
         r.status = STATUS_DONE;
         return r;
      end
      if (w.req_type != REQ_INSERT && w.req_type != REQ_LOOKUP) begin
         r.status = STATUS_MISSING;
         return r;
      end
      if (w.req_type == REQ_INSERT && entry_count + 1 >= slots) begin
         r.status = STATUS_FULL;
         return r;
      end
      perturb = w.hash_bits;
      slot    = w.hash_bits & mask;
      for (int n = 0; n < slots + ZERO_PERTURB_STEPS; n++) begin
         s = slot[SLOT_BITS-1:0];
         if (!occupied[s]) begin
            if (w.req_type == REQ_INSERT) begin
               occupied[s]     = 1'b1;
               stored_hash[s]  = w.hash_bits;
               stored_key[s]   = w.search_key;
               stored_value[s] = w.entry_value;
               entry_count++;
               r.status     = STATUS_DONE;
               r.slot_index = s;
            end else begin
               r.status = STATUS_MISSING;
            end
            return r;
         end
         if (w.req_type == REQ_LOOKUP && stored_hash[s] == w.hash_bits
             && stored_key[s] == w.search_key) begin
            r.status      = STATUS_FOUND;
            r.found_value = stored_value[s];
            r.slot_index  = s;
            return r;
         end
         perturb = perturb >> PROBE_SHIFT;
         slot    = (64'(PROBE_MUL) * 64'(s) + 64'd1 + perturb) & mask;
      end
      r.status = (w.req_type == REQ_INSERT) ? STATUS_FULL : STATUS_MISSING;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         size_log2  = SIZE_W'(SIZE_RESET);
         for (int i = 0; i < SLOT_DEPTH; i++) occupied[i] = 1'b0;
         entry_count = 0;
         awaited_rsp_q.delete();
      end else begin
         if (csr_wr_en) size_log2 = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp_q.size() == 0) begin
               $display("%0t: response word with none awaited, actual %h", $time, rsp_word);
               fail_count++;
            end else begin
               want = awaited_rsp_q.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_word.status));
               check_field("found_value", 64'(want.found_value), 64'(rsp_word.found_value));
               check_field("slot_index", 64'(want.slot_index), 64'(rsp_word.slot_index));
            end
         end
         if (req_valid && !req_stall) awaited_rsp_q.push_back(probe_table(req_word));
      end
      pending = awaited_rsp_q.size();
   end

endmodule

### tb/tb.sv
// Top of the hash table testbench: clock, reset, request and stall stimulus, and the verdict.
`timescale 1ns / 1ps

module tb;
   import pph_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         RANDOM_ITEMS = 2000;
   localparam int         CYCLE_LIMIT  = 8_000_000;
   localparam int         DRAIN_CYCLES = 20;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_word_type      req_word = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_word_type      rsp_word;
   logic              csr_wr_en = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = '0;
   int                fail_count;
   int                pending;

   int                cycle_count = 0;
   int                stall_left = 0;
   int                stall_roll;
   int                burst_left = 0;
   int                random_sent = 0;
   req_word_type      inserted_q[$];

   perturbed_probe_hash_table_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pph_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 55) begin
            rsp_stall  = 1'b0;
            stall_left = $urandom_range(0, 4);
         end else if (stall_roll < 90) begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(0, 3);
         end else if (stall_roll < 96) begin
            rsp_stall  = 1'b0;
            stall_left = $urandom_range(20, 60);
         end else begin
            rsp_stall  = 1'b1;
            stall_left = $urandom_range(10, 40);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (roll < 8) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_request(input req_word_type w);
      int idle;
      idle = pick_gap();
      if (idle > 0) begin
         req_valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_word  = w;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic [1:0] kind, input logic [63:0] hash,
                              input logic [63:0] key, input logic [31:0] value);
      req_word_type w;
      w.req_type    = kind;
      w.hash_bits   = hash;
      w.search_key  = key;
      w.entry_value = value;
      send_request(w);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] size);
      settle();
      csr_wr_data = size;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Builds one random request, mostly inserts and lookups aimed at what is already stored.
   function automatic req_word_type random_request();
      req_word_type w;
      req_word_type old;
      int           roll;
      int           sub;
      w.req_type    = REQ_INSERT;
      w.hash_bits   = rand64();
      w.search_key  = rand64();
      w.entry_value = $urandom;
      roll = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      if (inserted_q.size() > 0) old = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
      else old = w;
      if (sub < 8) w.hash_bits = 64'($urandom_range(0, 4095));
      if (roll < 3) begin
         w.req_type = REQ_CLEAR;
         inserted_q.delete();
      end else if (roll < 5) begin
         w.req_type = REQ_UNUSED;
      end else if (roll < 50) begin
         if (sub >= 10 && sub < 25) begin
            w.hash_bits = old.hash_bits;
         end else if (sub >= 25 && sub < 40) begin
            w.hash_bits[SLOT_BITS-1:0] = old.hash_bits[SLOT_BITS-1:0];
         end else if (sub >= 40 && sub < 50) begin
            w.hash_bits  = old.hash_bits;
            w.search_key = old.search_key;
         end
         inserted_q.push_back(w);
      end else if (roll < 85 && inserted_q.size() > 0) begin
         w.req_type   = REQ_LOOKUP;
         w.hash_bits  = old.hash_bits;
         w.search_key = old.search_key;
      end else begin
         w.req_type = REQ_LOOKUP;
         if (sub >= 50 && sub < 80) w.hash_bits = old.hash_bits;
      end
      return w;
   endfunction

   initial begin
      logic [SIZE_W-1:0] size;
      int                lg;
      int                phase_len;
      int                roll;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_fields(REQ_LOOKUP, '1, '1, $urandom);
      send_fields(REQ_INSERT, '0, '0, '0);
      send_fields(REQ_INSERT, '1, '1, '1);
      send_fields(REQ_LOOKUP, '0, '0, $urandom);
      send_fields(REQ_LOOKUP, '1, '1, '0);
      send_fields(REQ_INSERT, '0, '0, 32'h1234_5678);
      send_fields(REQ_LOOKUP, '0, 64'd1, $urandom);
      send_fields(REQ_INSERT, 64'h400, 64'd5, 32'd1);
      send_fields(REQ_LOOKUP, 64'h400, 64'd5, $urandom);
      send_fields(REQ_UNUSED, rand64(), rand64(), $urandom);
      send_fields(REQ_CLEAR, rand64(), rand64(), $urandom);
      send_fields(REQ_LOOKUP, '0, '0, $urandom);

      // Below the minimum the table has four slots, so the fourth insert is refused.
      write_size(4'd0);
      for (int i = 1; i <= 4; i++) send_fields(REQ_INSERT, 64'(i), 64'(i), $urandom);
      // Growing to eight slots leaves room for four more before the spare slot is reached.
      write_size(4'd3);
      send_fields(REQ_INSERT, 64'd0, 64'd0, $urandom);
      for (int i = 4; i <= 6; i++) send_fields(REQ_INSERT, 64'(i), 64'(i), $urandom);
      // Shrunk back to four full slots, a miss has to run the whole bounded walk.
      write_size(4'd2);
      send_fields(REQ_LOOKUP, 64'd7, 64'd7, $urandom);
      write_size(4'd15);
      send_fields(REQ_INSERT, rand64(), rand64(), $urandom);

      while (random_sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 19);
         if (roll < 12) size = 4'($urandom_range(2, 5));
         else if (roll < 16) size = 4'($urandom_range(6, 8));
         else if (roll < 18) size = 4'($urandom_range(9, 10));
         else if (roll < 19) size = 4'($urandom_range(0, 1));
         else size = 4'($urandom_range(11, 15));
         write_size(size);
         lg = int'(size);
         if (lg < MIN_LOG2) lg = MIN_LOG2;
         if (lg > SLOT_BITS) lg = SLOT_BITS;
         if ($urandom_range(0, 9) < 7) begin
            inserted_q.delete();
            send_fields(REQ_CLEAR, rand64(), rand64(), $urandom);
            random_sent++;
         end
         phase_len = (1 << lg) + $urandom_range(0, 1 << lg);
         if (phase_len > 120) phase_len = 120;
         if (phase_len < 8) phase_len = 8;
         repeat (phase_len) begin
            send_request(random_request());
            random_sent++;
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
